@@ design/mfa_pkg.sv @@
`timescale 1ns / 1ps
// shared constants and word types for the minifloat adder
// no dependencies

package mfa_pkg;

    localparam int EXP_BITS  = 5;
    localparam int FRAC_BITS = 10;
    localparam int MANT_BITS = FRAC_BITS + 1;          // with hidden one
    localparam int SUM_BITS  = FRAC_BITS + 2;          // with carry
    localparam int LZ_BITS   = $clog2(FRAC_BITS + 2);  // shift count 0..FRAC_BITS
    localparam int CMP_BITS  = EXP_BITS + LZ_BITS;

    typedef struct packed {
        logic                 a_sign;
        logic [EXP_BITS-1:0]  a_exp;
        logic [FRAC_BITS-1:0] a_frac;
        logic                 b_sign;
        logic [EXP_BITS-1:0]  b_exp;
        logic [FRAC_BITS-1:0] b_frac;
    } operand_word_t;

    typedef struct packed {
        logic                 sum_sign;
        logic [EXP_BITS-1:0]  sum_exp;
        logic [FRAC_BITS-1:0] sum_frac;
        logic                 overflowed;
    } result_word_t;

endpackage

@@ design/minifloat_adder.sv @@
`timescale 1ns / 1ps
// minifloat_adder: pipelined truncating floating-point adder
// depends on mfa_pkg
//
//  channel   | valid          | stall          | word
//  ----------+----------------+----------------+-----------------------------
//  operands  | operand_valid  | operand_stall  | operands  (a and b fields)
//  result    | result_valid   | result_stall   | result    (sum and flag)
//
// one word enters per cycle unless the output stalls, and passes in turn through
// the order, align/add, leading-zero count and normalize/output registers
// the throughput of one word per cycle is set by the single shared enable:
// every stage moves together when the output register is empty or taken
// a stall on result freezes every stage and raises operand_stall in the same
// cycle, so nothing is lost or repeated
// reset (rst_n low, asynchronous) clears only the valid bits of all stages

module minifloat_adder (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   operand_valid,
    output logic                   operand_stall,
    input  mfa_pkg::operand_word_t operands,
    output logic                   result_valid,
    input  logic                   result_stall,
    output mfa_pkg::result_word_t  result
);

    localparam int E  = mfa_pkg::EXP_BITS;
    localparam int F  = mfa_pkg::FRAC_BITS;
    localparam int M  = mfa_pkg::MANT_BITS;
    localparam int S  = mfa_pkg::SUM_BITS;
    localparam int LZ = mfa_pkg::LZ_BITS;
    localparam int CW = mfa_pkg::CMP_BITS;

    // whole pipe advances together
    logic adv;
    assign adv           = !(result_valid && result_stall);
    assign operand_stall = !adv;

    // ------------------------------------------------------------------
    // stage 1: zero checks and magnitude ordering
    // ------------------------------------------------------------------
    logic         s1_valid_reg;
    logic         s1_byp_reg,  s1_byp_next;      // result known already
    mfa_pkg::result_word_t s1_bres_reg, s1_bres_next;
    logic         s1_sign_reg, s1_sign_next;     // sign of larger operand
    logic         s1_sub_reg,  s1_sub_next;      // effective subtraction
    logic [E-1:0] s1_exp_reg,  s1_exp_next;
    logic [M-1:0] s1_lm_reg,   s1_lm_next;
    logic [M-1:0] s1_sm_reg,   s1_sm_next;
    logic [E-1:0] s1_dlt_reg,  s1_dlt_next;

    logic a_zero, b_zero, a_ge;

    always_comb
    begin
        a_zero = (operands.a_exp == '0);
        b_zero = (operands.b_exp == '0);
        a_ge   = (operands.a_exp > operands.b_exp) ||
                 ((operands.a_exp == operands.b_exp) && (operands.a_frac >= operands.b_frac));

        s1_byp_next  = a_zero || b_zero;
        s1_bres_next = '0;
        if (a_zero && !b_zero)
        begin
            s1_bres_next.sum_sign = operands.b_sign;
            s1_bres_next.sum_exp  = operands.b_exp;
            s1_bres_next.sum_frac = operands.b_frac;
        end
        else if (b_zero && !a_zero)
        begin
            s1_bres_next.sum_sign = operands.a_sign;
            s1_bres_next.sum_exp  = operands.a_exp;
            s1_bres_next.sum_frac = operands.a_frac;
        end

        s1_sub_next = operands.a_sign ^ operands.b_sign;
        if (a_ge)
        begin
            s1_sign_next = operands.a_sign;
            s1_exp_next  = operands.a_exp;
            s1_lm_next   = {1'b1, operands.a_frac};
            s1_sm_next   = {1'b1, operands.b_frac};
            s1_dlt_next  = operands.a_exp - operands.b_exp;
        end
        else
        begin
            s1_sign_next = operands.b_sign;
            s1_exp_next  = operands.b_exp;
            s1_lm_next   = {1'b1, operands.b_frac};
            s1_sm_next   = {1'b1, operands.a_frac};
            s1_dlt_next  = operands.b_exp - operands.a_exp;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: alignment shift (shifted-out bits dropped) and add/subtract
    // ------------------------------------------------------------------
    logic         s2_valid_reg;
    logic         s2_byp_reg,  s2_byp_next;
    mfa_pkg::result_word_t s2_bres_reg, s2_bres_next;
    logic         s2_sign_reg, s2_sign_next;
    logic         s2_sub_reg,  s2_sub_next;
    logic [E-1:0] s2_exp_reg,  s2_exp_next;
    logic [S-1:0] s2_sum_reg,  s2_sum_next;

    logic [M-1:0] sm_al;

    always_comb
    begin
        if (s1_dlt_reg > E'(F))
            sm_al = '0;
        else
            sm_al = s1_sm_reg >> s1_dlt_reg;

        if (s1_sub_reg)
            s2_sum_next = {1'b0, s1_lm_reg} - {1'b0, sm_al};
        else
            s2_sum_next = {1'b0, s1_lm_reg} + {1'b0, sm_al};

        s2_byp_next  = s1_byp_reg;
        s2_bres_next = s1_bres_reg;
        s2_sign_next = s1_sign_reg;
        s2_sub_next  = s1_sub_reg;
        s2_exp_next  = s1_exp_reg;
    end

    // ------------------------------------------------------------------
    // stage 3: carry handling on the add path, leading-zero count on the
    // subtract path; cancellation and bypass become final results here
    // ------------------------------------------------------------------
    logic          s3_valid_reg;
    logic          s3_norm_reg, s3_norm_next;    // left normalize needed
    logic          s3_sign_reg, s3_sign_next;
    logic [E-1:0]  s3_exp_reg,  s3_exp_next;
    logic [M-1:0]  s3_mant_reg, s3_mant_next;
    logic [LZ-1:0] s3_lz_reg,   s3_lz_next;
    logic          s3_ovf_reg,  s3_ovf_next;

    logic [LZ-1:0] lz_cnt;

    always_comb
    begin
        // priority encoder, highest set bit wins
        lz_cnt = '0;
        for (int i = 0; i <= F; i++)
        begin
            if (s2_sum_reg[i])
                lz_cnt = LZ'(F - i);
        end

        s3_norm_next = 1'b0;
        s3_sign_next = s2_sign_reg;
        s3_exp_next  = s2_exp_reg;
        s3_mant_next = s2_sum_reg[M-1:0];
        s3_lz_next   = '0;
        s3_ovf_next  = 1'b0;

        if (s2_byp_reg)
        begin
            s3_sign_next = s2_bres_reg.sum_sign;
            s3_exp_next  = s2_bres_reg.sum_exp;
            s3_mant_next = {1'b0, s2_bres_reg.sum_frac};
        end
        else if (s2_sub_reg)
        begin
            if (s2_sum_reg == '0)
            begin
                // exact cancellation gives +0
                s3_sign_next = 1'b0;
                s3_exp_next  = '0;
                s3_mant_next = '0;
            end
            else
            begin
                s3_norm_next = 1'b1;
                s3_lz_next   = lz_cnt;
            end
        end
        else if (s2_sum_reg[S-1])
        begin
            if (s2_exp_reg == '1)
            begin
                // saturate to largest finite value
                s3_exp_next  = '1;
                s3_mant_next = '1;
                s3_ovf_next  = 1'b1;
            end
            else
            begin
                s3_exp_next  = s2_exp_reg + E'(1);
                s3_mant_next = s2_sum_reg[S-1:1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 4: left shift, exponent lowering, underflow flush
    // ------------------------------------------------------------------
    logic                  out_valid_reg;
    mfa_pkg::result_word_t out_word_reg, out_word_next;

    logic [CW-1:0] exp_ext, lz_ext, exp_diff;
    logic [M-1:0]  mant_sh;

    always_comb
    begin
        exp_ext  = CW'(s3_exp_reg);
        lz_ext   = CW'(s3_lz_reg);
        exp_diff = exp_ext - lz_ext;
        mant_sh  = s3_mant_reg << s3_lz_reg;

        out_word_next.sum_sign   = s3_sign_reg;
        out_word_next.sum_exp    = s3_exp_reg;
        out_word_next.sum_frac   = s3_mant_reg[F-1:0];
        out_word_next.overflowed = s3_ovf_reg;

        if (s3_norm_reg)
        begin
            if (exp_ext <= lz_ext)
                out_word_next = '0;   // underflow flushes to +0
            else
            begin
                out_word_next.sum_exp  = exp_diff[E-1:0];
                out_word_next.sum_frac = mant_sh[F-1:0];
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= operand_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_byp_reg   <= s1_byp_next;
            s1_bres_reg  <= s1_bres_next;
            s1_sign_reg  <= s1_sign_next;
            s1_sub_reg   <= s1_sub_next;
            s1_exp_reg   <= s1_exp_next;
            s1_lm_reg    <= s1_lm_next;
            s1_sm_reg    <= s1_sm_next;
            s1_dlt_reg   <= s1_dlt_next;

            s2_byp_reg   <= s2_byp_next;
            s2_bres_reg  <= s2_bres_next;
            s2_sign_reg  <= s2_sign_next;
            s2_sub_reg   <= s2_sub_next;
            s2_exp_reg   <= s2_exp_next;
            s2_sum_reg   <= s2_sum_next;

            s3_norm_reg  <= s3_norm_next;
            s3_sign_reg  <= s3_sign_next;
            s3_exp_reg   <= s3_exp_next;
            s3_mant_reg  <= s3_mant_next;
            s3_lz_reg    <= s3_lz_next;
            s3_ovf_reg   <= s3_ovf_next;

            out_word_reg <= out_word_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

endmodule

@@ design/mfa_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for minifloat_adder, bound into every instance of it
// depends on mfa_pkg and minifloat_adder

module mfa_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   operand_valid,
    input logic                   operand_stall,
    input logic                   result_valid,
    input logic                   result_stall,
    input mfa_pkg::result_word_t  result
);

    // a held word does not change
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // no backpressure upstream unless the output is blocked
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !result_stall |-> !operand_stall)
        else $error("operand stall without result stall");

    // an accepted word reaches the output when nothing stalls
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (operand_valid && !operand_stall && !result_stall) ##1 !result_stall
            ##1 !result_stall ##1 !result_stall |=> result_valid)
        else $error("accepted word did not reach the output");

    // saturation gives the largest finite value
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.overflowed |->
            result.sum_exp == '1 && result.sum_frac == '1)
        else $error("overflow without saturated word");

    // every zero result is +0
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.sum_exp == '0 |->
            !result.sum_sign && result.sum_frac == '0 && !result.overflowed)
        else $error("zero result not clean +0");

endmodule

bind minifloat_adder mfa_checker u_mfa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .operand_valid (operand_valid),
    .operand_stall (operand_stall),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
);

@@ test/minifloat_adder_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for minifloat_adder: directed corner words, then random words
// depends on mfa_pkg and minifloat_adder; predicts every sum in place, no files

module minifloat_adder_tb;

    // run length and receiver pressure
    localparam int RANDOM_WORDS   = 830;
    localparam int HOLD_AFTER     = 300;    // sums taken before the long hold-off
    localparam int HOLD_CYCLES    = 48;     // long enough to fill every pipeline stage
    localparam int DRAIN_CYCLES   = 8;      // pipeline is four registers deep
    localparam int TIMEOUT_NS     = 400_000;
    localparam int PRINT_LIMIT    = 20;

    typedef logic [mfa_pkg::EXP_BITS-1:0]  exp_field_t;
    typedef logic [mfa_pkg::FRAC_BITS-1:0] frac_field_t;

    localparam exp_field_t  EXP_TOP  = '1;
    localparam frac_field_t FRAC_TOP = '1;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   operand_valid = 1'b0;
    logic                   operand_stall;
    mfa_pkg::operand_word_t operands = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    mfa_pkg::result_word_t  result;

    // words waiting to be offered, and sums the block still owes us
    mfa_pkg::operand_word_t pending_operands[$];
    mfa_pkg::result_word_t  expected_sums[$];

    int total_words;
    int directed_words;
    int words_accepted;
    int sums_checked;
    int saturated_sums;
    int zero_sums;
    int mismatch_count;

    // sender side pacing
    int unsigned send_gap;
    logic        send_calm;
    logic        holding;

    // receiver side pacing
    int unsigned stall_wait;
    int unsigned hold_left;
    int unsigned wait_next;
    int unsigned hold_next;
    logic        recv_calm;
    logic        hold_done;

    minifloat_adder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_valid (operand_valid),
        .operand_stall (operand_stall),
        .operands      (operands),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // expected sum of one operand word: align the smaller magnitude, add or
    // subtract, then normalize with truncation, saturation and flush to zero
    function automatic mfa_pkg::result_word_t predict_sum(mfa_pkg::operand_word_t op);
        mfa_pkg::result_word_t         r;
        logic                          big_sign;
        logic                          small_sign;
        exp_field_t                    big_exp;
        exp_field_t                    small_exp;
        logic [mfa_pkg::FRAC_BITS:0]   big_sig;
        logic [mfa_pkg::FRAC_BITS:0]   small_sig;
        logic [mfa_pkg::FRAC_BITS+1:0] acc;
        int                            gap;
        int                            exp_now;
        r = '0;
        // a zero exponent field means the operand is zero
        if (op.a_exp == 0 && op.b_exp == 0)
            return r;
        if (op.a_exp == 0)
        begin
            r.sum_sign = op.b_sign;
            r.sum_exp  = op.b_exp;
            r.sum_frac = op.b_frac;
            return r;
        end
        if (op.b_exp == 0)
        begin
            r.sum_sign = op.a_sign;
            r.sum_exp  = op.a_exp;
            r.sum_frac = op.a_frac;
            return r;
        end
        // larger magnitude first, a wins a tie
        if ({op.a_exp, op.a_frac} >= {op.b_exp, op.b_frac})
        begin
            big_sign   = op.a_sign;
            big_exp    = op.a_exp;
            big_sig    = {1'b1, op.a_frac};
            small_sign = op.b_sign;
            small_exp  = op.b_exp;
            small_sig  = {1'b1, op.b_frac};
        end
        else
        begin
            big_sign   = op.b_sign;
            big_exp    = op.b_exp;
            big_sig    = {1'b1, op.b_frac};
            small_sign = op.a_sign;
            small_exp  = op.a_exp;
            small_sig  = {1'b1, op.a_frac};
        end
        gap = int'(big_exp) - int'(small_exp);
        if (gap > mfa_pkg::FRAC_BITS)
            small_sig = '0;
        else
            small_sig = small_sig >> gap;
        exp_now = int'(big_exp);
        if (big_sign == small_sign)
        begin
            acc = big_sig + small_sig;
            if (acc[mfa_pkg::FRAC_BITS+1])
            begin
                acc = acc >> 1;
                if (exp_now == int'(EXP_TOP))
                begin
                    // saturate to the largest finite value
                    r.sum_sign   = big_sign;
                    r.sum_exp    = EXP_TOP;
                    r.sum_frac   = FRAC_TOP;
                    r.overflowed = 1'b1;
                    return r;
                end
                exp_now++;
            end
        end
        else
        begin
            acc = big_sig - small_sig;
            if (acc == 0)
                return r;
            while (!acc[mfa_pkg::FRAC_BITS])
            begin
                acc = acc << 1;
                if (exp_now <= 1)
                    return '0;
                exp_now--;
            end
        end
        r.sum_sign = big_sign;
        r.sum_exp  = exp_field_t'(exp_now);
        r.sum_frac = acc[mfa_pkg::FRAC_BITS-1:0];
        return r;
    endfunction

    function automatic mfa_pkg::operand_word_t make_operands(int as, int ae, int af,
                                                             int bs, int be, int bf);
        mfa_pkg::operand_word_t w;
        w.a_sign = (as != 0);
        w.a_exp  = exp_field_t'(ae);
        w.a_frac = frac_field_t'(af);
        w.b_sign = (bs != 0);
        w.b_exp  = exp_field_t'(be);
        w.b_frac = frac_field_t'(bf);
        return w;
    endfunction

    // random operand pair, biased toward the interesting regions
    function automatic mfa_pkg::operand_word_t random_operands();
        mfa_pkg::operand_word_t w;
        w = mfa_pkg::operand_word_t'($urandom);
        case ($urandom_range(0, 9))
            4:
            begin
                // near cancellation: close exponents, close fractions
                w.b_sign = !w.a_sign;
                w.b_exp  = w.a_exp ^ exp_field_t'($urandom_range(0, 1));
                w.b_frac = w.a_frac ^ frac_field_t'($urandom_range(0, 15));
            end
            5:
            begin
                // exact cancellation
                w.b_sign = !w.a_sign;
                w.b_exp  = w.a_exp;
                w.b_frac = w.a_frac;
            end
            6:
            begin
                // top of the range, same sign, overflow likely
                w.a_exp  = exp_field_t'($urandom_range(29, 31));
                w.b_exp  = exp_field_t'($urandom_range(29, 31));
                w.b_sign = w.a_sign;
            end
            7:
            begin
                // bottom of the range, opposite signs, underflow likely
                w.a_exp  = exp_field_t'($urandom_range(1, 3));
                w.b_exp  = exp_field_t'($urandom_range(1, 3));
                w.b_sign = !w.a_sign;
            end
            8:
            begin
                if ($urandom_range(0, 1))
                    w.a_exp = '0;
                else
                    w.b_exp = '0;
            end
            9:
            begin
                // gaps around the fraction width
                if (w.a_exp > 12)
                    w.b_exp = w.a_exp - exp_field_t'($urandom_range(9, 12));
                else
                    w.b_exp = w.a_exp + exp_field_t'($urandom_range(9, 12));
            end
            default:
            begin
            end
        endcase
        return w;
    endfunction

    // idle cycles before the next word; none at all while calm
    function automatic int unsigned draw_wait(logic calm);
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // compare one taken result word against the oldest expected sum
    task automatic check_sum(mfa_pkg::result_word_t got);
        mfa_pkg::result_word_t want;
        if (expected_sums.size() == 0)
        begin
            report_mismatch($sformatf("result word %h with no sum outstanding", got));
            return;
        end
        want = expected_sums.pop_front();
        sums_checked++;
        if (want.overflowed)
            saturated_sums++;
        if (want.sum_exp == 0)
            zero_sums++;
        if (got.sum_sign !== want.sum_sign)
            report_mismatch($sformatf("sum %0d sign got %b want %b",
                                      sums_checked, got.sum_sign, want.sum_sign));
        if (got.sum_exp !== want.sum_exp)
            report_mismatch($sformatf("sum %0d exponent got %h want %h",
                                      sums_checked, got.sum_exp, want.sum_exp));
        if (got.sum_frac !== want.sum_frac)
            report_mismatch($sformatf("sum %0d fraction got %h want %h",
                                      sums_checked, got.sum_frac, want.sum_frac));
        if (got.overflowed !== want.overflowed)
            report_mismatch($sformatf("sum %0d overflow flag got %b want %b",
                                      sums_checked, got.overflowed, want.overflowed));
    endtask

    // sender: offers words from the pending queue, holds a stalled word
    // steady, and predicts the sum of every word at the edge it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operand_valid <= 1'b0;
            operands      <= '0;
            send_gap      <= 0;
            send_calm     <= 1'b0;
        end
        else
        begin
            holding = operand_valid && operand_stall;
            if (operand_valid && !operand_stall)
            begin
                expected_sums.push_back(predict_sum(operands));
                words_accepted++;
            end
            // a word stays up across a take only through this single assignment
            if (!holding)
            begin
                if (send_gap == 0 && pending_operands.size() != 0)
                begin
                    operands      <= pending_operands.pop_front();
                    operand_valid <= 1'b1;
                    send_gap      <= draw_wait(send_calm);
                    if ($urandom_range(0, 31) == 0)
                        send_calm <= !send_calm;
                end
                else
                begin
                    operand_valid <= 1'b0;
                    if (send_gap != 0)
                        send_gap <= send_gap - 1;
                end
            end
        end
    end

    // receiver: checks each taken word, then stalls for a drawn count;
    // once, after HOLD_AFTER sums, it holds off long enough that the
    // pipeline fills and the block must stall its operand side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_wait   <= 0;
            hold_left    <= 0;
            recv_calm    <= 1'b0;
            hold_done    <= 1'b0;
        end
        else
        begin
            wait_next = (stall_wait != 0) ? stall_wait - 1 : 0;
            hold_next = (hold_left != 0) ? hold_left - 1 : 0;
            if (result_valid && !result_stall)
            begin
                check_sum(result);
                wait_next = draw_wait(recv_calm);
                if ($urandom_range(0, 31) == 0)
                    recv_calm <= !recv_calm;
                if (!hold_done && sums_checked >= HOLD_AFTER)
                begin
                    hold_next = HOLD_CYCLES;
                    hold_done <= 1'b1;
                end
            end
            stall_wait   <= wait_next;
            hold_left    <= hold_next;
            result_stall <= (wait_next != 0) || (hold_next != 0);
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        // zero operands, with junk fractions behind a zero exponent
        pending_operands.push_back(make_operands(1, 0, 10'h3FF, 1, 0, 10'h155));
        pending_operands.push_back(make_operands(0, 0, 10'h000, 0, 0, 10'h000));
        pending_operands.push_back(make_operands(0, 0, 10'h2AA, 1, 17, 10'h123));
        pending_operands.push_back(make_operands(1, 31, 10'h3FF, 0, 0, 10'h3FF));
        pending_operands.push_back(make_operands(1, 0, 10'h000, 1, 31, 10'h3FF));
        // exact cancellation, both sign orders
        pending_operands.push_back(make_operands(0, 15, 10'h155, 1, 15, 10'h155));
        pending_operands.push_back(make_operands(1, 22, 10'h3FF, 0, 22, 10'h3FF));
        // exponent gaps just over, at and far over the fraction width
        pending_operands.push_back(make_operands(0, 20, 10'h000, 0, 9, 10'h3FF));
        pending_operands.push_back(make_operands(0, 20, 10'h000, 0, 10, 10'h3FF));
        pending_operands.push_back(make_operands(0, 3, 10'h0AB, 1, 31, 10'h000));
        pending_operands.push_back(make_operands(0, 16, 10'h001, 0, 5, 10'h3FF));
        // carry out, with and without saturation
        pending_operands.push_back(make_operands(0, 31, 10'h3FF, 0, 31, 10'h3FF));
        pending_operands.push_back(make_operands(1, 31, 10'h200, 1, 30, 10'h200));
        pending_operands.push_back(make_operands(0, 10, 10'h3FF, 0, 10, 10'h3FF));
        pending_operands.push_back(make_operands(1, 10, 10'h000, 1, 10, 10'h000));
        pending_operands.push_back(make_operands(0, 1, 10'h000, 0, 1, 10'h000));
        // left normalization, down to flush to zero
        pending_operands.push_back(make_operands(0, 1, 10'h001, 1, 1, 10'h000));
        pending_operands.push_back(make_operands(1, 2, 10'h000, 0, 1, 10'h3FF));
        pending_operands.push_back(make_operands(0, 20, 10'h000, 1, 19, 10'h3FF));
        pending_operands.push_back(make_operands(1, 12, 10'h001, 0, 12, 10'h000));
        pending_operands.push_back(make_operands(0, 31, 10'h000, 1, 30, 10'h3FF));
        // larger operand second with opposite signs, then a far smaller b with the same sign
        pending_operands.push_back(make_operands(1, 5, 10'h3FF, 0, 16, 10'h001));
        pending_operands.push_back(make_operands(1, 31, 10'h3FF, 1, 1, 10'h000));
        directed_words = pending_operands.size();

        repeat (RANDOM_WORDS)
            pending_operands.push_back(random_operands());
        total_words = pending_operands.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (words_accepted < total_words)
            @(posedge clk);
        while (expected_sums.size() != 0)
            @(posedge clk);
        // anything arriving now has no sum behind it and is flagged
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d operand words (%0d directed corners, rest random)",
                 total_words, directed_words);
        $display("checked %0d sums: %0d saturated, %0d zero, %0d bad fields",
                 sums_checked, saturated_sums, zero_sums, mismatch_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog for a hung handshake
    initial
    begin
        #(TIMEOUT_NS);
        $display("timed out with %0d of %0d words taken, %0d sums outstanding",
                 words_accepted, total_words, expected_sums.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
